>>> design/cfd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Checksummed frame deframer package
// Shared types, byte codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package cfd_pkg;

  localparam logic [7:0] HDR_FIRST  = 8'hFF;
  localparam logic [7:0] HDR_SECOND = 8'hFB;
  localparam logic [7:0] ID_LIMIT   = 8'hF1;

  localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
  localparam logic [7:0]  ACCEPT_RESET  = 8'd26;
  localparam logic [7:0]  MIN_LEN_RESET = 8'd50;
  localparam logic [7:0]  MAX_LEN_RESET = 8'd150;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_TIMEOUT = 2'd0,
    REG_ACCEPT  = 2'd1,
    REG_MIN_LEN = 2'd2,
    REG_MAX_LEN = 2'd3
  } cfg_reg_t;

  typedef enum logic [0:0] {
    KIND_PAYLOAD = 1'b0,
    KIND_VERDICT = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    STATUS_OK     = 2'd0,
    STATUS_CKSUM  = 2'd1,
    STATUS_BAD_ID = 2'd2
  } status_t;

  typedef struct packed {
    logic [15:0] timeout_limit;
    logic [7:0]  accepted_id;
    logic [7:0]  min_length;
    logic [7:0]  max_length;
  } cfd_cfg_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data_byte;
    logic [7:0]  byte_index;
    logic [7:0]  frame_id;
    logic [7:0]  frame_length;
    logic [1:0]  status;
    logic        link_up;
    logic [15:0] checksum_errors;
  } cfd_result_t;

endpackage

>>> design/cfd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Checksummed frame deframer channels
// Valid/ready channels for received bytes and for parser results.
// ----------------------------------------------------------------------------
interface cfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface cfd_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  data_byte;
  logic [7:0]  byte_index;
  logic [7:0]  frame_id;
  logic [7:0]  frame_length;
  logic [1:0]  status;
  logic        link_up;
  logic [15:0] checksum_errors;

  modport source (
    output valid, output kind, output data_byte, output byte_index, output frame_id,
    output frame_length, output status, output link_up, output checksum_errors,
    input ready
  );
  modport sink (
    input valid, input kind, input data_byte, input byte_index, input frame_id,
    input frame_length, input status, input link_up, input checksum_errors,
    output ready
  );
endinterface

>>> design/cfd_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame parser
// Header hunt, length check, payload pass-through and checksum and id verdict.
// ----------------------------------------------------------------------------
module cfd_parser
  import cfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cfd_cfg_t    cfg,
  input  logic        in_fire,
  input  logic [7:0]  in_byte,
  output logic        res_valid,
  output cfd_result_t res
);

  typedef enum logic [5:0] {
    PH_HUNT    = 6'b000001,
    PH_GOT_FF  = 6'b000010,
    PH_GOT_FB  = 6'b000100,
    PH_GOT_ID  = 6'b001000,
    PH_PAYLOAD = 6'b010000,
    PH_CHECK   = 6'b100000
  } phase_t;

  phase_t      phase, phase_next, phase_eff;
  logic [15:0] idle_cnt, idle_cnt_next, cnt_inc, cnt_eff;
  logic [7:0]  remaining, remaining_next;
  logic [7:0]  pay_cnt, pay_cnt_next;
  logic [7:0]  sum, sum_next;
  logic [7:0]  cur_id, cur_id_next;
  logic [7:0]  cur_len, cur_len_next;
  logic        link_flag, link_flag_next;
  logic [15:0] err_tally, err_tally_next;
  logic        timed_out;

  always_comb begin
    cnt_inc   = (idle_cnt == 16'hFFFF) ? idle_cnt : idle_cnt + 16'd1;
    timed_out = cnt_inc > cfg.timeout_limit;
    phase_eff = timed_out ? PH_HUNT : phase;
    cnt_eff   = timed_out ? 16'd0 : cnt_inc;

    phase_next     = (in_byte == HDR_FIRST) ? PH_GOT_FF : PH_HUNT;
    idle_cnt_next  = cnt_eff;
    remaining_next = remaining;
    pay_cnt_next   = pay_cnt;
    sum_next       = (in_byte == HDR_FIRST) ? in_byte : sum;
    cur_id_next    = cur_id;
    cur_len_next   = cur_len;
    link_flag_next = link_flag;
    err_tally_next = err_tally;
    res_valid      = 1'b0;
    res.kind       = KIND_PAYLOAD;
    res.data_byte  = in_byte;
    res.byte_index = pay_cnt;
    res.status     = STATUS_OK;

    unique case (phase_eff)
      PH_HUNT: begin
        if (in_byte == HDR_FIRST) begin
          idle_cnt_next = 16'd0;
        end
      end
      PH_GOT_FF: begin
        if (in_byte == HDR_SECOND) begin
          phase_next    = PH_GOT_FB;
          sum_next      = sum + in_byte;
          idle_cnt_next = 16'd0;
        end else if (in_byte == HDR_FIRST) begin
          idle_cnt_next = 16'd0;
        end
      end
      PH_GOT_FB: begin
        if (in_byte != 8'd0 && in_byte < ID_LIMIT) begin
          phase_next    = PH_GOT_ID;
          cur_id_next   = in_byte;
          sum_next      = sum + in_byte;
          idle_cnt_next = 16'd0;
        end
      end
      PH_GOT_ID: begin
        idle_cnt_next = 16'd0;
        if (in_byte < cfg.min_length || in_byte > cfg.max_length) begin
          phase_next = PH_HUNT;
          sum_next   = sum;
        end else begin
          phase_next     = PH_PAYLOAD;
          cur_len_next   = in_byte;
          remaining_next = in_byte;
          pay_cnt_next   = 8'd0;
          sum_next       = sum + in_byte;
        end
      end
      PH_PAYLOAD: begin
        if (remaining != 8'd0) begin
          res_valid      = 1'b1;
          remaining_next = remaining - 8'd1;
          sum_next       = sum + in_byte;
          pay_cnt_next   = pay_cnt + 8'd1;
          if (remaining == 8'd1) begin
            phase_next    = PH_CHECK;
            idle_cnt_next = 16'd0;
          end else begin
            phase_next = PH_PAYLOAD;
          end
        end
      end
      PH_CHECK: begin
        res_valid      = 1'b1;
        res.kind       = KIND_VERDICT;
        res.data_byte  = 8'd0;
        res.byte_index = 8'd0;
        phase_next     = PH_HUNT;
        sum_next       = sum;
        idle_cnt_next  = 16'd0;
        if (sum != in_byte) begin
          res.status = STATUS_CKSUM;
          if (err_tally != 16'hFFFF) begin
            err_tally_next = err_tally + 16'd1;
          end
        end else if (cur_id != cfg.accepted_id) begin
          res.status = STATUS_BAD_ID;
        end else begin
          link_flag_next = 1'b1;
        end
      end
      default: begin
      end
    endcase

    res.frame_id        = cur_id;
    res.frame_length    = cur_len;
    res.link_up         = link_flag_next;
    res.checksum_errors = err_tally_next;
    res_valid           = res_valid & in_fire;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_HUNT;
      idle_cnt  <= 16'd0;
      remaining <= 8'd0;
      pay_cnt   <= 8'd0;
      sum       <= 8'd0;
      cur_id    <= 8'd0;
      cur_len   <= 8'd0;
      link_flag <= 1'b0;
      err_tally <= 16'd0;
    end else if (in_fire) begin
      phase     <= phase_next;
      idle_cnt  <= idle_cnt_next;
      remaining <= remaining_next;
      pay_cnt   <= pay_cnt_next;
      sum       <= sum_next;
      cur_id    <= cur_id_next;
      cur_len   <= cur_len_next;
      link_flag <= link_flag_next;
      err_tally <= err_tally_next;
    end
  end

endmodule

>>> design/checksummed_frame_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Checksummed frame deframer
// Bytes enter on in_ch one item per cycle while in_ch.ready is high. Each item
// is either dropped into the parser state or turned into one result on out_ch:
// a payload byte with its index, or the end-of-frame verdict after the checksum
// byte. The parser takes one item per cycle while in_ch.ready is high, set by
// its single registered state update. An output register and a skid register
// follow the parser, so a stalled receiver costs no input cycle until both
// hold a result; in_ch.ready then drops until out_ch takes one. Reset clears
// the parser to header hunt, clears the link flag and the error count, empties
// the output stages and loads the default register values. The write port
// (cfg_we, cfg_index, cfg_data) updates the timeout, the accepted id and the
// length bounds; the user must write it only while no frame traffic is
// pending, and the block itself does not enforce it.
// ----------------------------------------------------------------------------
module checksummed_frame_deframer
  import cfd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  cfd_in_if.sink                 in_ch,
  cfd_out_if.source              out_ch
);

  cfd_cfg_t    cfg;
  logic        in_fire;
  logic        res_valid;
  cfd_result_t res;
  logic        out_valid, skid_valid;
  cfd_result_t out_res, skid_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.timeout_limit <= TIMEOUT_RESET;
      cfg.accepted_id   <= ACCEPT_RESET;
      cfg.min_length    <= MIN_LEN_RESET;
      cfg.max_length    <= MAX_LEN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_TIMEOUT: cfg.timeout_limit <= cfg_data;
        REG_ACCEPT:  cfg.accepted_id   <= cfg_data[7:0];
        REG_MIN_LEN: cfg.min_length    <= cfg_data[7:0];
        REG_MAX_LEN: cfg.max_length    <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  assign in_ch.ready = !skid_valid;
  assign in_fire     = in_ch.valid && !skid_valid;

  cfd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_fire   (in_fire),
    .in_byte   (in_ch.in_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ch.ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ch.ready) begin
      out_res <= skid_valid ? skid_res : res;
    end else if (res_valid) begin
      skid_res <= res;
    end
  end

  assign out_ch.valid           = out_valid;
  assign out_ch.kind            = out_res.kind;
  assign out_ch.data_byte       = out_res.data_byte;
  assign out_ch.byte_index      = out_res.byte_index;
  assign out_ch.frame_id        = out_res.frame_id;
  assign out_ch.frame_length    = out_res.frame_length;
  assign out_ch.status          = out_res.status;
  assign out_ch.link_up         = out_res.link_up;
  assign out_ch.checksum_errors = out_res.checksum_errors;

endmodule

>>> sim/cfd_stream_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deframer stream checker
// Watches the byte and result channels and the register write port. Every
// accepted byte runs through an independent frame parser, and every accepted
// result is compared field by field with the oldest predicted result.
// ----------------------------------------------------------------------------
module cfd_stream_checker
  import cfd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  cfd_in_if                      in_ch,
  cfd_out_if                     out_ch,
  output int                     mismatch_count,
  output int                     results_owed
);

  typedef enum logic [2:0] {
    HUNT_FF    = 3'd0,
    SEEN_FF    = 3'd1,
    SEEN_FB    = 3'd2,
    SEEN_ID    = 3'd3,
    IN_PAYLOAD = 3'd4,
    WANT_SUM   = 3'd5
  } hunt_phase_t;

  cfd_cfg_t    settings;
  hunt_phase_t phase;
  logic [15:0] byte_age;
  logic [7:0]  left_to_go;
  logic [7:0]  payload_pos;
  logic [7:0]  frame_sum;
  logic [7:0]  cur_id;
  logic [7:0]  cur_len;
  logic        link_seen;
  logic [15:0] sum_faults;
  cfd_result_t pending_results[$];
  int          mismatches = 0;

  task automatic parse_byte(input logic [7:0] b);
    cfd_result_t r;
    logic        emit;
    r = '0;
    emit = 1'b0;
    if (byte_age != 16'hFFFF) byte_age = byte_age + 16'd1;
    if (byte_age > settings.timeout_limit) begin
      phase = HUNT_FF;
      byte_age = '0;
    end
    if (phase == HUNT_FF && b == HDR_FIRST) begin
      phase = SEEN_FF;
      frame_sum = b;
      byte_age = '0;
    end else if (phase == SEEN_FF && b == HDR_SECOND) begin
      phase = SEEN_FB;
      frame_sum = frame_sum + b;
      byte_age = '0;
    end else if (phase == SEEN_FF && b == HDR_FIRST) begin
      frame_sum = b;
      byte_age = '0;
    end else if (phase == SEEN_FB && b != 8'h00 && b < ID_LIMIT) begin
      phase = SEEN_ID;
      cur_id = b;
      frame_sum = frame_sum + b;
      byte_age = '0;
    end else if (phase == SEEN_ID) begin
      byte_age = '0;
      if (b < settings.min_length || b > settings.max_length) begin
        phase = HUNT_FF;
      end else begin
        phase = IN_PAYLOAD;
        cur_len = b;
        left_to_go = b;
        payload_pos = '0;
        frame_sum = frame_sum + b;
      end
    end else if (phase == IN_PAYLOAD && left_to_go != 8'd0) begin
      left_to_go = left_to_go - 8'd1;
      frame_sum = frame_sum + b;
      r.kind = KIND_PAYLOAD;
      r.data_byte = b;
      r.byte_index = payload_pos;
      r.status = STATUS_OK;
      emit = 1'b1;
      payload_pos = payload_pos + 8'd1;
      if (left_to_go == 8'd0) begin
        phase = WANT_SUM;
        byte_age = '0;
      end
    end else if (phase == WANT_SUM) begin
      phase = HUNT_FF;
      byte_age = '0;
      r.kind = KIND_VERDICT;
      if (frame_sum != b) begin
        r.status = STATUS_CKSUM;
        if (sum_faults != 16'hFFFF) sum_faults = sum_faults + 16'd1;
      end else if (cur_id != settings.accepted_id) begin
        r.status = STATUS_BAD_ID;
      end else begin
        r.status = STATUS_OK;
        link_seen = 1'b1;
      end
      emit = 1'b1;
    end else if (b == HDR_FIRST) begin
      phase = SEEN_FF;
      frame_sum = b;
    end else begin
      phase = HUNT_FF;
    end
    if (emit) begin
      r.frame_id = cur_id;
      r.frame_length = cur_len;
      r.link_up = link_seen;
      r.checksum_errors = sum_faults;
      pending_results.push_back(r);
    end
  endtask

  task automatic compare_field(input string name, input logic [15:0] want,
                               input logic [15:0] seen);
    if (seen !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, seen);
      mismatches++;
    end
  endtask

  task automatic check_result();
    cfd_result_t want;
    cfd_result_t seen;
    seen.kind = out_ch.kind;
    seen.data_byte = out_ch.data_byte;
    seen.byte_index = out_ch.byte_index;
    seen.frame_id = out_ch.frame_id;
    seen.frame_length = out_ch.frame_length;
    seen.status = out_ch.status;
    seen.link_up = out_ch.link_up;
    seen.checksum_errors = out_ch.checksum_errors;
    if (pending_results.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual %h", $time, seen);
      mismatches++;
    end else begin
      want = pending_results.pop_front();
      compare_field("kind", 16'(want.kind), 16'(seen.kind));
      compare_field("data_byte", 16'(want.data_byte), 16'(seen.data_byte));
      compare_field("byte_index", 16'(want.byte_index), 16'(seen.byte_index));
      compare_field("frame_id", 16'(want.frame_id), 16'(seen.frame_id));
      compare_field("frame_length", 16'(want.frame_length), 16'(seen.frame_length));
      compare_field("status", 16'(want.status), 16'(seen.status));
      compare_field("link_up", 16'(want.link_up), 16'(seen.link_up));
      compare_field("checksum_errors", want.checksum_errors, seen.checksum_errors);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      settings.timeout_limit = TIMEOUT_RESET;
      settings.accepted_id = ACCEPT_RESET;
      settings.min_length = MIN_LEN_RESET;
      settings.max_length = MAX_LEN_RESET;
      phase = HUNT_FF;
      byte_age = '0;
      left_to_go = '0;
      payload_pos = '0;
      frame_sum = '0;
      cur_id = '0;
      cur_len = '0;
      link_seen = 1'b0;
      sum_faults = '0;
      pending_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_TIMEOUT: settings.timeout_limit = cfg_data;
          REG_ACCEPT:  settings.accepted_id = cfg_data[7:0];
          REG_MIN_LEN: settings.min_length = cfg_data[7:0];
          REG_MAX_LEN: settings.max_length = cfg_data[7:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) parse_byte(in_ch.in_byte);
      if (out_ch.valid && out_ch.ready) check_result();
    end
    mismatch_count <= mismatches;
    results_owed <= pending_results.size();
  end

endmodule

>>> sim/checksummed_frame_deframer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Checksummed frame deframer testbench
// Drives received bytes with random gaps and stalls the result channel at
// random. A short directed sequence covers header resync, rejected ids and
// lengths, all three verdicts and the byte timeout; random traffic of mostly
// well-formed frames then runs under a series of register settings.
// ----------------------------------------------------------------------------
module checksummed_frame_deframer_tb;
  import cfd_pkg::*;

  typedef logic [7:0] byte_q_t[$];

  localparam int STUCK_LIMIT  = 1000;
  localparam int RANDOM_ITEMS = 1000;

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  int         mismatch_count;
  int         results_owed;
  int         stuck_cycles;
  int         sent;
  bit         steady;
  logic [7:0] want_id;
  logic [7:0] len_lo;
  logic [7:0] len_hi;

  cfd_in_if  in_ch ();
  cfd_out_if out_ch ();

  checksummed_frame_deframer dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  cfd_stream_checker stream_check (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .mismatch_count (mismatch_count),
    .results_owed   (results_owed)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    int hold;
    hold = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        out_ch.ready <= 1'b0;
      end else if (out_ch.valid && out_ch.ready) begin
        hold = steady ? 0 : $urandom_range(0, 8);
        out_ch.ready <= (hold == 0);
      end else if (hold != 0) begin
        hold = hold - 1;
        out_ch.ready <= (hold == 0);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.in_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    sent++;
  endtask

  task automatic send_all(input byte_q_t q);
    foreach (q[i]) send_byte(q[i]);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_settings(input logic [15:0] limit, input logic [7:0] id,
                               input logic [7:0] lo, input logic [7:0] hi);
    cfg_we <= 1'b1;
    cfg_index <= REG_TIMEOUT;
    cfg_data <= limit;
    @(posedge clk);
    cfg_index <= REG_ACCEPT;
    cfg_data <= {8'h00, id};
    @(posedge clk);
    cfg_index <= REG_MIN_LEN;
    cfg_data <= {8'h00, lo};
    @(posedge clk);
    cfg_index <= REG_MAX_LEN;
    cfg_data <= {8'h00, hi};
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    want_id = id;
    len_lo = lo;
    len_hi = hi;
  endtask

  function automatic byte_q_t random_bytes(input int n);
    byte_q_t q;
    repeat (n) q.push_back(8'($urandom_range(0, 255)));
    return q;
  endfunction

  function automatic byte_q_t build_frame(input logic [7:0] id, input logic [7:0] len,
                                          input byte_q_t body, input bit spoil);
    byte_q_t    q;
    logic [7:0] sum;
    q = '{HDR_FIRST, HDR_SECOND, id, len};
    foreach (body[i]) q.push_back(body[i]);
    sum = '0;
    foreach (q[i]) sum = sum + q[i];
    q.push_back(spoil ? sum + 8'd1 : sum);
    return q;
  endfunction

  function automatic logic [7:0] pick_length();
    int span;
    if (len_lo > len_hi) return 8'($urandom_range(0, 10));
    span = int'(len_hi) - int'(len_lo);
    if (span > 12 && $urandom_range(0, 19) != 0) span = 12;
    return 8'(len_lo + $urandom_range(0, span));
  endfunction

  function automatic logic [7:0] pick_bad_length();
    if (len_lo > 8'd1) return 8'($urandom_range(0, len_lo - 1));
    if (len_hi < 8'd255) return 8'($urandom_range(len_hi + 1, 255));
    return 8'd0;
  endfunction

  function automatic logic [7:0] pick_bad_id();
    int k;
    k = $urandom_range(0, 15);
    return (k == 0) ? 8'h00 : 8'(ID_LIMIT + k - 1);
  endfunction

  function automatic byte_q_t well_formed_frame();
    logic [7:0] id;
    logic [7:0] len;
    id = ($urandom_range(0, 4) != 0) ? want_id : 8'($urandom_range(1, 240));
    len = pick_length();
    return build_frame(id, len, random_bytes(int'(len)), $urandom_range(0, 4) == 0);
  endfunction

  task automatic run_traffic(input int budget);
    int      stop_at;
    int      pick;
    int      cut;
    byte_q_t q;
    stop_at = sent + budget;
    while (sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 2) begin
        drain_results();
      end else if (pick < 72) begin
        send_all(well_formed_frame());
      end else if (pick < 82) begin
        q = well_formed_frame();
        cut = $urandom_range(0, q.size() - 2);
        send_all(q[0:cut]);
      end else if (pick < 86) begin
        send_all(build_frame(pick_bad_id(), pick_length(),
                             random_bytes($urandom_range(0, 3)), 1'b0));
      end else if (pick < 90) begin
        send_all(build_frame(want_id, pick_bad_length(),
                             random_bytes($urandom_range(0, 3)), 1'b0));
      end else begin
        repeat ($urandom_range(1, 4)) begin
          send_byte(($urandom_range(0, 3) == 0) ? HDR_FIRST : 8'($urandom_range(0, 255)));
        end
      end
    end
  endtask

  task automatic traffic_phase(input logic [15:0] limit, input logic [7:0] id,
                               input logic [7:0] lo, input logic [7:0] hi,
                               input int budget, input bit calm);
    drain_results();
    load_settings(limit, id, lo, hi);
    steady = calm || ($urandom_range(0, 3) == 0);
    run_traffic(budget);
  endtask

  initial begin
    logic [15:0] lim;
    logic [7:0]  lo;
    logic [7:0]  hi;
    clk = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_TIMEOUT;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.in_byte = '0;
    steady = 1'b0;
    sent = 0;
    want_id = ACCEPT_RESET;
    len_lo = MIN_LEN_RESET;
    len_hi = MAX_LEN_RESET;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    send_all('{HDR_FIRST, HDR_SECOND, ID_LIMIT, HDR_FIRST, HDR_FIRST, HDR_SECOND,
               ACCEPT_RESET, MIN_LEN_RESET - 8'd1});
    drain_results();
    load_settings(16'd1, 8'd240, 8'd1, 8'd2);
    send_all(build_frame(8'd240, 8'd1, '{8'h00}, 1'b0));
    send_all(build_frame(8'd1, 8'd1, '{8'hFF}, 1'b0));
    send_all(build_frame(8'd240, 8'd1, '{8'h5A}, 1'b1));
    send_all('{HDR_FIRST, HDR_SECOND, 8'd1, 8'd2, 8'hAA, 8'h55});

    traffic_phase(TIMEOUT_RESET, ACCEPT_RESET, MIN_LEN_RESET, MAX_LEN_RESET, 250, 1'b0);
    traffic_phase(16'd65534, 8'd1, 8'd1, 8'd8, 150, 1'b1);
    traffic_phase(16'd3, 8'd240, 8'd1, 8'd6, 100, 1'b0);
    traffic_phase(16'd1, 8'd5, 8'd1, 8'd4, 60, 1'b0);
    traffic_phase(16'd65534, 8'd240, 8'd255, 8'd255, 0, 1'b0);
    send_all(build_frame(8'd240, 8'd255, random_bytes(255), 1'b0));
    traffic_phase(16'd500, 8'd17, 8'd200, 8'd1, 60, 1'b0);
    while (sent < RANDOM_ITEMS) begin
      lim = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(1, 30))
                                         : 16'($urandom_range(31, 65534));
      lo = 8'($urandom_range(1, 8));
      hi = 8'(lo + $urandom_range(0, 12));
      if (hi > 8'd1) hi = hi - 8'd1;
      traffic_phase(lim, 8'($urandom_range(1, 240)), lo, hi, 80, 1'b0);
    end

    drain_results();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
